@@ rtl/core/taq_pkg.sv @@
// Shared constants, types and the CORDIC arctangent table for the tilt angle quantizer.
package taq_pkg;

  localparam int ACCEL_BITS_DEF = 16;
  localparam int LIMIT_W        = 15;
  localparam int CFG_INDEX_W    = 8;
  localparam int CODE_W         = 8;
  localparam int QDEPTH         = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_TILT_LIMIT     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VERTICAL_LIMIT = 8'd1;

  localparam logic [LIMIT_W-1:0] TILT_LIMIT_RST     = 15'd1638;
  localparam logic [LIMIT_W-1:0] VERTICAL_LIMIT_RST = 15'd3973;

  localparam logic [CODE_W-1:0] CODE_DEAD  = 8'd128;
  localparam logic [CODE_W-1:0] CODE_POS_X = 8'd127;
  localparam logic [CODE_W-1:0] CODE_NEG_X = 8'd255;

  // CORDIC datapath: magnitudes are aligned so that their top lands at bit FRAC_POS - 1
  localparam int CORDIC_STEPS = 31;
  localparam int FRAC_POS     = 60;
  localparam int CW           = FRAC_POS + 2;
  localparam int ZW           = 32;
  localparam int ATAN_W       = 30;
  localparam int ALPHA_W      = 31;
  localparam int THETA_W      = 32;

  localparam logic [ALPHA_W-1:0] QUARTER_TURN = 31'd1073741824;
  localparam logic [THETA_W:0]   HALF_TURN    = 33'd2147483648;
  localparam logic [THETA_W:0]   FULL_TURN    = 33'd4294967296;

  typedef struct packed {
    logic                forced;
    logic                dead;
    logic [CODE_W-1:0]   code;
    logic                x_neg;
    logic                y_neg;
  } item_ctl_t;

  // atan(2^-i) in units of 2^32 per turn, rounded
  function automatic logic [ATAN_W-1:0] turn_atan(input int unsigned i);
    logic [ATAN_W-1:0] t;
    case (i)
      0:  t = 30'd536870912;
      1:  t = 30'd316933406;
      2:  t = 30'd167458907;
      3:  t = 30'd85004756;
      4:  t = 30'd42667331;
      5:  t = 30'd21354465;
      6:  t = 30'd10679838;
      7:  t = 30'd5340245;
      8:  t = 30'd2670163;
      9:  t = 30'd1335087;
      10: t = 30'd667544;
      11: t = 30'd333772;
      12: t = 30'd166886;
      13: t = 30'd83443;
      14: t = 30'd41722;
      15: t = 30'd20861;
      16: t = 30'd10430;
      17: t = 30'd5215;
      18: t = 30'd2608;
      19: t = 30'd1304;
      20: t = 30'd652;
      21: t = 30'd326;
      22: t = 30'd163;
      23: t = 30'd81;
      24: t = 30'd41;
      25: t = 30'd20;
      26: t = 30'd10;
      27: t = 30'd5;
      28: t = 30'd3;
      29: t = 30'd1;
      30: t = 30'd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/tilt_angle_quantizer.sv @@
// Top level of the tilt angle quantizer: front end, item queue and angle pipeline.
//
// Usage
//   Drive accel_x, accel_y and accel_z (two's complement, 4096 LSB per g) and
//   raise start; the sample is taken at a rising edge with start high and busy
//   low. One sample may be taken every cycle.
//   The front end classifies each sample against the tilt and vertical limits
//   and pushes it into a two-entry queue; the back end drains that queue one
//   beat per cycle into a 31-stage CORDIC pipeline, one rotation per stage,
//   followed by a quadrant stage and a scaling stage.
//   done is high for one cycle, with angle_code and in_dead_zone valid
//   alongside it. Throughput is one beat per cycle, set by the
//   one-rotation-per-stage pipeline; busy rises only if the queue fills,
//   which the free-running back end prevents.
//   The result strobe cannot be held off: the receiver must take each beat.
//   Limits are written through cfg_valid/cfg_ready with cfg_index 0 for the
//   tilt limit and 1 for the vertical limit; other indexes are dropped.
//   Reset (rst, synchronous) empties the queue and the pipeline and restores
//   the limits to 0.4 g and 0.97 g.
module tilt_angle_quantizer #(
  parameter int ACCEL_BITS = taq_pkg::ACCEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ACCEL_BITS-1:0]    accel_x,
  input  logic signed [ACCEL_BITS-1:0]    accel_y,
  input  logic signed [ACCEL_BITS-1:0]    accel_z,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [taq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [taq_pkg::LIMIT_W-1:0]     cfg_data,
  output logic                            done,
  output logic [taq_pkg::CODE_W-1:0]      angle_code,
  output logic                            in_dead_zone
);
  import taq_pkg::*;

  // queue beat: both magnitudes plus the classification
  localparam int QW = 2 * ACCEL_BITS + $bits(item_ctl_t);

  logic                  push;
  logic [ACCEL_BITS-1:0] push_ax;
  logic [ACCEL_BITS-1:0] push_ay;
  item_ctl_t             push_ctl;
  logic                  queue_full;
  logic                  q_valid;
  logic [QW-1:0]         q_data;
  logic [ACCEL_BITS-1:0] q_ax;
  logic [ACCEL_BITS-1:0] q_ay;
  item_ctl_t             q_ctl;

  taq_front #(
    .ACCEL_BITS (ACCEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .queue_full (queue_full),
    .busy       (busy),
    .accel_x    (accel_x),
    .accel_y    (accel_y),
    .accel_z    (accel_z),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_ax    (push_ax),
    .push_ay    (push_ay),
    .push_ctl   (push_ctl)
  );

  // the back end never stalls, so pop whenever a beat waits
  taq_queue #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  ({push_ax, push_ay, push_ctl}),
    .rd_en    (q_valid),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .full     (queue_full)
  );

  assign {q_ax, q_ay, q_ctl} = q_data;

  taq_back #(
    .ACCEL_BITS (ACCEL_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ax        (q_ax),
    .in_ay        (q_ay),
    .in_ctl       (q_ctl),
    .done         (done),
    .angle_code   (angle_code),
    .in_dead_zone (in_dead_zone)
  );

endmodule

@@ rtl/core/taq_front.sv @@
// Front end: limit registers, sample acceptance and dead zone classification.
module taq_front #(
  parameter int ACCEL_BITS = taq_pkg::ACCEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               queue_full,
  output logic                               busy,
  input  logic signed [ACCEL_BITS-1:0]       accel_x,
  input  logic signed [ACCEL_BITS-1:0]       accel_y,
  input  logic signed [ACCEL_BITS-1:0]       accel_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [taq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [taq_pkg::LIMIT_W-1:0]        cfg_data,
  output logic                               push,
  output logic [ACCEL_BITS-1:0]              push_ax,
  output logic [ACCEL_BITS-1:0]              push_ay,
  output taq_pkg::item_ctl_t                 push_ctl
);
  import taq_pkg::*;

  localparam int CMP_W = (ACCEL_BITS > LIMIT_W) ? ACCEL_BITS : LIMIT_W;

  logic [LIMIT_W-1:0]    tilt_limit;
  logic [LIMIT_W-1:0]    vertical_limit;
  logic [ACCEL_BITS-1:0] mag_x;
  logic [ACCEL_BITS-1:0] mag_y;
  logic [ACCEL_BITS-1:0] mag_z;
  logic                  x_zero;
  logic                  y_zero;
  logic                  dead;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_limit     <= TILT_LIMIT_RST;
      vertical_limit <= VERTICAL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TILT_LIMIT:     tilt_limit     <= cfg_data;
        REG_VERTICAL_LIMIT: vertical_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // the most negative value negates to an exact unsigned magnitude
  assign mag_x  = accel_x[ACCEL_BITS-1] ? (~accel_x + 1'b1) : accel_x;
  assign mag_y  = accel_y[ACCEL_BITS-1] ? (~accel_y + 1'b1) : accel_y;
  assign mag_z  = accel_z[ACCEL_BITS-1] ? (~accel_z + 1'b1) : accel_z;
  assign x_zero = (accel_x == '0);
  assign y_zero = (accel_y == '0);

  assign dead = (CMP_W'(mag_z) > CMP_W'(tilt_limit)) ||
                (CMP_W'(mag_x) > CMP_W'(vertical_limit)) ||
                (x_zero && y_zero);

  assign busy    = queue_full;
  assign push    = start && !busy;
  assign push_ax = mag_x;
  assign push_ay = mag_y;

  always_comb begin
    push_ctl.x_neg = accel_x[ACCEL_BITS-1];
    push_ctl.y_neg = accel_y[ACCEL_BITS-1];
    push_ctl.dead  = dead;
    priority if (dead) begin
      push_ctl.forced = 1'b1;
      push_ctl.code   = CODE_DEAD;
    end else if (y_zero) begin
      push_ctl.forced = 1'b1;
      push_ctl.code   = accel_x[ACCEL_BITS-1] ? CODE_NEG_X : CODE_POS_X;
    end else begin
      push_ctl.forced = 1'b0;
      push_ctl.code   = CODE_DEAD;
    end
  end

endmodule

@@ rtl/core/taq_queue.sv @@
// Short first-in first-out queue between the front end and the angle pipeline.
module taq_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = taq_pkg::QDEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  output logic             full
);
  import taq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == NW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/taq_back.sv @@
// Back end: pipelined CORDIC vectoring, quadrant mapping and code scaling.
module taq_back #(
  parameter int ACCEL_BITS = taq_pkg::ACCEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [ACCEL_BITS-1:0]         in_ax,
  input  logic [ACCEL_BITS-1:0]         in_ay,
  input  taq_pkg::item_ctl_t            in_ctl,
  output logic                          done,
  output logic [taq_pkg::CODE_W-1:0]    angle_code,
  output logic                          in_dead_zone
);
  import taq_pkg::*;

  localparam int SHIFT = FRAC_POS - ACCEL_BITS;

  logic [CORDIC_STEPS:0]  sv;
  logic signed [CW-1:0]   sx [0:CORDIC_STEPS];
  logic signed [CW-1:0]   sy [0:CORDIC_STEPS];
  logic signed [ZW-1:0]   sz [0:CORDIC_STEPS];
  item_ctl_t              sc [0:CORDIC_STEPS];

  logic [ALPHA_W-1:0]     alpha;
  logic [THETA_W:0]       theta_wide;
  logic [THETA_W-1:0]     theta_next;
  logic [THETA_W-1:0]     theta;
  logic                   tv;
  item_ctl_t              tc;
  logic [THETA_W+CODE_W-1:0] scaled;

  // align magnitudes into the wide datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= in_valid;
    end
    sx[0] <= signed'({{(CW-FRAC_POS){1'b0}}, in_ax, {SHIFT{1'b0}}});
    sy[0] <= signed'({{(CW-FRAC_POS){1'b0}}, in_ay, {SHIFT{1'b0}}});
    sz[0] <= '0;
    sc[0] <= in_ctl;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 y_pos;

    assign dx    = sy[i] >>> i;
    assign dy    = sx[i] >>> i;
    assign y_pos = !sy[i][CW-1] && (sy[i] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else begin
        sv[i+1] <= sv[i];
      end
      sc[i+1] <= sc[i];
      if (y_pos) begin
        sx[i+1] <= sx[i] + dx;
        sy[i+1] <= sy[i] - dy;
        sz[i+1] <= sz[i] + signed'(ZW'(turn_atan(i)));
      end else begin
        sx[i+1] <= sx[i] - dx;
        sy[i+1] <= sy[i] + dy;
        sz[i+1] <= sz[i] - signed'(ZW'(turn_atan(i)));
      end
    end
  end

  // clamp to the first quadrant, then place it by the signs of x and y
  always_comb begin
    priority if (sz[CORDIC_STEPS][ZW-1]) begin
      alpha = '0;
    end else if (sz[CORDIC_STEPS][ZW-2:0] > QUARTER_TURN) begin
      alpha = QUARTER_TURN;
    end else begin
      alpha = sz[CORDIC_STEPS][ALPHA_W-1:0];
    end
    unique case ({sc[CORDIC_STEPS].y_neg, sc[CORDIC_STEPS].x_neg})
      2'b00:   theta_wide = HALF_TURN - (THETA_W+1)'(alpha);
      2'b01:   theta_wide = (THETA_W+1)'(alpha);
      2'b10:   theta_wide = HALF_TURN + (THETA_W+1)'(alpha);
      default: theta_wide = FULL_TURN - (THETA_W+1)'(alpha);
    endcase
    theta_next = theta_wide[THETA_W] ? '1 : theta_wide[THETA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
    end else begin
      tv <= sv[CORDIC_STEPS];
    end
    theta <= theta_next;
    tc    <= sc[CORDIC_STEPS];
  end

  // theta * 255 as theta * 256 - theta
  assign scaled = {theta, {CODE_W{1'b0}}} - {{CODE_W{1'b0}}, theta};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tv;
    end
    angle_code   <= tc.forced ? tc.code : scaled[THETA_W+CODE_W-1:THETA_W];
    in_dead_zone <= tc.dead;
  end

endmodule

@@ sim/tilt_angle_checker.sv @@
// Checker for the tilt angle quantizer: mirrors the limits, predicts each result and compares it.
module tilt_angle_checker #(
  parameter int ACCEL_BITS = taq_pkg::ACCEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [ACCEL_BITS-1:0]        accel_x,
  input  logic signed [ACCEL_BITS-1:0]        accel_y,
  input  logic signed [ACCEL_BITS-1:0]        accel_z,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [taq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [taq_pkg::LIMIT_W-1:0]         cfg_data,
  input  logic                                done,
  input  logic [taq_pkg::CODE_W-1:0]          angle_code,
  input  logic                                in_dead_zone,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  results_seen,
  output int                                  dead_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import taq_pkg::*;

  localparam int     ALIGN      = FRAC_POS - ACCEL_BITS;
  localparam longint QUARTER_T  = 64'sd1073741824;
  localparam longint HALF_T     = 64'sd2147483648;
  localparam longint FULL_T     = 64'sd4294967296;
  localparam int     REPORT_CAP = 150;

  typedef struct {
    logic signed [ACCEL_BITS-1:0] x;
    logic signed [ACCEL_BITS-1:0] y;
    logic signed [ACCEL_BITS-1:0] z;
    logic [CODE_W-1:0]            code;
    logic                         dead;
  } wheel_angle_t;

  // atan(2^-i) in turn units, 2^32 per turn
  longint atan_turns [0:CORDIC_STEPS-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1
  };

  logic [LIMIT_W-1:0] tilt_q = TILT_LIMIT_RST;
  logic [LIMIT_W-1:0] vert_q = VERTICAL_LIMIT_RST;
  wheel_angle_t       angle_fifo [$];
  wheel_angle_t       want;
  int                 reported = 0;

  // First-quadrant angle of (ax, ay) by vectoring, clamped to a quarter turn
  function automatic longint cordic_turns(input longint ax, input longint ay);
    longint cx, cy, cz, dx, dy;
    cx = ax <<< ALIGN;
    cy = ay <<< ALIGN;
    cz = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx;
        cy -= dy;
        cz += atan_turns[i];
      end else begin
        cx -= dx;
        cy += dy;
        cz -= atan_turns[i];
      end
    end
    if (cz < 0) cz = 0;
    if (cz > QUARTER_T) cz = QUARTER_T;
    return cz;
  endfunction

  function automatic wheel_angle_t predict_wheel_angle(
    input logic signed [ACCEL_BITS-1:0] sx,
    input logic signed [ACCEL_BITS-1:0] sy,
    input logic signed [ACCEL_BITS-1:0] sz
  );
    wheel_angle_t r;
    longint x, y, z, mx, mz, alpha, theta;
    r.x = sx;
    r.y = sy;
    r.z = sz;
    r.dead = 1'b0;
    x = sx;
    y = sy;
    z = sz;
    mx = (x < 0) ? -x : x;
    mz = (z < 0) ? -z : z;
    if (mz > longint'(tilt_q) || mx > longint'(vert_q) || (x == 0 && y == 0)) begin
      r.code = CODE_DEAD;
      r.dead = 1'b1;
    end else if (y == 0) begin
      r.code = (x > 0) ? CODE_POS_X : CODE_NEG_X;
    end else begin
      alpha = cordic_turns(mx, (y < 0) ? -y : y);
      if (y > 0) theta = (x >= 0) ? HALF_T - alpha : alpha;
      else theta = (x >= 0) ? HALF_T + alpha : FULL_T - alpha;
      if (theta < 0) theta = 0;
      if (theta > FULL_T - 1) theta = FULL_T - 1;
      r.code = CODE_W'((theta * 255) >>> 32);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tilt_q = TILT_LIMIT_RST;
      vert_q = VERTICAL_LIMIT_RST;
      angle_fifo.delete();
      outstanding <= 0;
    end else begin
      if (done) begin
        if (angle_fifo.size() == 0) begin
          mismatches++;
          if (reported++ < REPORT_CAP)
            $display("%0t: result beat with nothing expected, got code %0d dead %0b",
                     $time, angle_code, in_dead_zone);
        end else begin
          want = angle_fifo.pop_front();
          results_seen++;
          if (in_dead_zone) dead_seen++;
          if (angle_code !== want.code) begin
            mismatches++;
            if (reported++ < REPORT_CAP)
              $display("%0t: angle_code for x=%0d y=%0d z=%0d expected %0d got %0d",
                       $time, want.x, want.y, want.z, want.code, angle_code);
          end
          if (in_dead_zone !== want.dead) begin
            mismatches++;
            if (reported++ < REPORT_CAP)
              $display("%0t: in_dead_zone for x=%0d y=%0d z=%0d expected %0b got %0b",
                       $time, want.x, want.y, want.z, want.dead, in_dead_zone);
          end
        end
      end
      // Predict with the limits in force before this edge
      if (start && !busy) angle_fifo.push_back(predict_wheel_angle(accel_x, accel_y, accel_z));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TILT_LIMIT:     tilt_q = cfg_data;
          REG_VERTICAL_LIMIT: vert_q = cfg_data;
          default: ;
        endcase
      end
      outstanding <= angle_fifo.size();
    end
  end

endmodule

@@ sim/tb_tilt_angle_quantizer.sv @@
// Testbench top for the tilt angle quantizer: clock, reset, sample and limit stimulus, verdict.
module tb_tilt_angle_quantizer;
  timeunit 1ns;
  timeprecision 1ps;
  import taq_pkg::*;

  localparam int AB          = ACCEL_BITS_DEF;
  localparam int ACCEL_MAX   = (1 << (AB - 1)) - 1;
  localparam int ACCEL_MIN   = -(1 << (AB - 1));
  localparam int LIMIT_MAX   = (1 << LIMIT_W) - 1;
  localparam int PHASE_ITEMS = 90;
  localparam int DRAIN_LIMIT = 400;
  // Allow a margin beyond the pipeline latency to catch stray result beats
  localparam int TAIL_CYCLES = 48;

  // Indexes outside the register map: writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = REG_VERTICAL_LIMIT + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP   = '1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [AB-1:0]    accel_x = '0;
  logic signed [AB-1:0]    accel_y = '0;
  logic signed [AB-1:0]    accel_z = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [LIMIT_W-1:0]      cfg_data = '0;
  logic                    done;
  logic [CODE_W-1:0]       angle_code;
  logic                    in_dead_zone;

  int mismatches, outstanding, results_seen, dead_seen;

  // Limits currently in force, used only to shape the stimulus
  int tilt_now = int'(TILT_LIMIT_RST);
  int vert_now = int'(VERTICAL_LIMIT_RST);

  int burst_left = 0;
  int samples_sent = 0;
  int settings_used = 1;
  int reg_beats = 0;
  int failures;
  int drain;

  tilt_angle_quantizer #(.ACCEL_BITS(AB)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .angle_code   (angle_code),
    .in_dead_zone (in_dead_zone)
  );

  tilt_angle_checker #(.ACCEL_BITS(AB)) u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .angle_code   (angle_code),
    .in_dead_zone (in_dead_zone),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .dead_seen    (dead_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one sample and hold it until the block takes the beat. The sender
  // works in bursts: at the end of a burst drop start for a random gap, and
  // now and then run a long burst with no gaps at all. Start is only lowered
  // here when time advances afterwards, so it is never dropped and raised in
  // the same step.
  task automatic send_sample(input int x, input int y, input int z);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(30, 80);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
      end
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start   <= 1'b1;
    accel_x <= AB'(x);
    accel_y <= AB'(y);
    accel_z <= AB'(z);
    do @(posedge clk); while (busy);
    burst_left--;
    samples_sent++;
  endtask

  // Drop start and wait until every expected result has come back
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One beat on the limit channel; valid stays high for back-to-back beats
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LIMIT_W'(data);
    do @(posedge clk); while (!cfg_ready);
    reg_beats++;
  endtask

  // Change both limits while the block is idle, optionally with a beat to an
  // unmapped index that the block must ignore
  task automatic set_limits(input int tilt, input int vert, input bit with_spare);
    wait_idle();
    if (with_spare)
      write_reg($urandom_range(0, 1) ? REG_SPARE : REG_TOP, $urandom_range(0, LIMIT_MAX));
    write_reg(REG_TILT_LIMIT, tilt);
    write_reg(REG_VERTICAL_LIMIT, vert);
    cfg_valid <= 1'b0;
    tilt_now = tilt;
    vert_now = vert;
    settings_used++;
  endtask

  function automatic int spread(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Just inside or just outside a limit, either sign
  function automatic int at_edge(input int lim);
    int v;
    v = lim + int'($urandom_range(0, 1));
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  function automatic int corner();
    case ($urandom_range(0, 4))
      0: return ACCEL_MIN;
      1: return ACCEL_MAX;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // Mostly samples inside both limits so that they reach the angle pipeline,
  // with raw noise, limit edges, axis samples and field extremes mixed in
  task automatic random_sample();
    logic signed [AB-1:0] raw_x, raw_y, raw_z;
    int x, y, z;
    raw_x = $urandom();
    raw_y = $urandom();
    raw_z = $urandom();
    x = raw_x;
    y = raw_y;
    z = raw_z;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        x = spread(vert_now);
        z = spread(tilt_now);
        // shrink y now and then for shallow angles near the x axis
        if ($urandom_range(0, 1)) y = y >>> $urandom_range(0, AB - 2);
      end
      6: ;
      7: begin
        x = at_edge(vert_now);
        z = at_edge(tilt_now);
      end
      8: begin
        x = spread(vert_now);
        z = spread(tilt_now);
        if ($urandom_range(0, 1)) x = 0;
        else y = 0;
      end
      default: begin
        x = corner();
        y = corner();
        z = corner();
      end
    endcase
    send_sample(x, y, z);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset limits: zero vector, both x axis directions, pure y, quadrants,
    // limit edges, tilt, and an angle just below a full turn
    send_sample(0, 0, 0);
    send_sample(1000, 0, 0);
    send_sample(-1000, 0, 0);
    send_sample(0, 1000, 0);
    send_sample(0, -1000, 0);
    send_sample(1000, 1000, 0);
    send_sample(-1000, 1000, 0);
    send_sample(1000, -1000, 0);
    send_sample(-1000, -1000, 0);
    send_sample(int'(VERTICAL_LIMIT_RST), 1, int'(TILT_LIMIT_RST));
    send_sample(-int'(VERTICAL_LIMIT_RST) - 1, 5, 0);
    send_sample(0, 5, int'(TILT_LIMIT_RST) + 1);
    send_sample(0, 5, ACCEL_MIN);
    send_sample(-int'(VERTICAL_LIMIT_RST), -1, -int'(TILT_LIMIT_RST));
    send_sample(1, ACCEL_MIN, 0);
    send_sample(-1, ACCEL_MAX, 0);

    // Widest limits: the most negative value must still be out of range
    set_limits(LIMIT_MAX, LIMIT_MAX, 1'b0);
    send_sample(ACCEL_MIN, 5, 0);
    send_sample(ACCEL_MAX, ACCEL_MIN, ACCEL_MAX);
    send_sample(-ACCEL_MAX, ACCEL_MIN, -ACCEL_MAX);
    send_sample(0, 0, ACCEL_MIN);

    // Zero limits: only samples with x and z both zero get through
    set_limits(0, 0, 1'b1);
    send_sample(0, ACCEL_MIN, 0);
    send_sample(0, 5, 1);

    // Random phases under a spread of limit settings
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_limits(int'(TILT_LIMIT_RST), int'(VERTICAL_LIMIT_RST), $urandom_range(0, 1));
        1: set_limits(LIMIT_MAX, LIMIT_MAX, $urandom_range(0, 1));
        2: set_limits($urandom_range(0, LIMIT_MAX), $urandom_range(0, LIMIT_MAX),
                      $urandom_range(0, 1));
        3: set_limits(0, LIMIT_MAX, $urandom_range(0, 1));
        default: set_limits($urandom_range(0, 8191), $urandom_range(0, 8191), 1'b1);
      endcase
      repeat (PHASE_ITEMS) random_sample();
    end

    // Drain, then hold on a little longer to catch any stray result beat
    start <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (outstanding != 0 && drain < DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);

    failures = mismatches;
    if (outstanding != 0) begin
      failures++;
      $display("%0t: %0d expected results never arrived", $time, outstanding);
    end

    $display("Sent %0d samples over %0d limit settings with %0d register beats.",
             samples_sent, settings_used, reg_beats);
    $display("Checked %0d results, %0d of them in the dead zone; %0d mismatches.",
             results_seen, dead_seen, mismatches);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: the whole run needs well under a tenth of this
  initial begin
    #2000000;
    $display("%0t: run timed out with %0d results outstanding", $time, outstanding);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/taq_pkg.sv
rtl/core/taq_front.sv
rtl/core/taq_queue.sv
rtl/core/taq_back.sv
rtl/core/tilt_angle_quantizer.sv
sim/tilt_angle_checker.sv
sim/tb_tilt_angle_quantizer.sv
